// ===== src/ggb_pkg.sv =====
package ggb_pkg;

    // Default frame size limits
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    // Size register reset values and lower bound
    localparam logic [11:0] WIDTH_RST  = 12'd640;
    localparam logic [11:0] HEIGHT_RST = 12'd480;
    localparam int          MIN_SIZE   = 7;

    // Window geometry
    localparam int WIN       = 7;
    localparam int HALF_WIN  = 3;
    localparam int LINE_ROWS = WIN - 1;

    // Grey conversion: (307 R + 604 G + 113 B) >> 10
    localparam int          GREY_W    = 18;
    localparam logic [9:0]  COEF_RED  = 10'd307;
    localparam logic [9:0]  COEF_GRN  = 10'd604;
    localparam logic [9:0]  COEF_BLU  = 10'd113;
    localparam int          GREY_SHIFT = 10;

    // Kernel, weights sum to 1068
    localparam int KW_W = 7;
    localparam logic [KW_W-1:0] KERNEL [WIN][WIN] = '{
        '{7'd0, 7'd0,  7'd0,   7'd5,   7'd0,   7'd0,  7'd0},
        '{7'd0, 7'd5,  7'd18,  7'd32,  7'd18,  7'd5,  7'd0},
        '{7'd0, 7'd18, 7'd64,  7'd100, 7'd64,  7'd18, 7'd0},
        '{7'd5, 7'd32, 7'd100, 7'd100, 7'd100, 7'd32, 7'd5},
        '{7'd0, 7'd18, 7'd64,  7'd100, 7'd64,  7'd18, 7'd0},
        '{7'd0, 7'd5,  7'd18,  7'd32,  7'd18,  7'd5,  7'd0},
        '{7'd0, 7'd0,  7'd0,   7'd5,   7'd0,   7'd0,  7'd0}
    };

    // Row partial sum: at most 374 * 255, full sum at most 1068 * 255
    localparam int PART_W = 17;
    localparam int SUM_W  = 19;

    // Division by 1068: q = (x * 502689) >> 29, exact for every x below 2^19
    localparam int                 DIV_MULT_W = 19;
    localparam logic [DIV_MULT_W-1:0] DIV_MULT = 19'd502689;
    localparam int                 DIV_SHIFT  = 29;
    localparam int                 PROD_W     = SUM_W + DIV_MULT_W;

    // Output coordinate width
    localparam int COORD_W = 11;

    // Register map, indexed by paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;
    localparam int   PADDR_W    = 3;

    // Per-cell control
    typedef struct packed {
        logic rd_en;   // read the line at the new pixel's column
        logic wr_en;   // write back and shift the window row
        logic sum_en;  // register the row partial sum
    } cell_ctl_t;

    // Result tag carried alongside the pixel
    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
    } meta_t;

endpackage

// ===== src/ggb_line_cell.sv =====
// One window row: a line buffer (all rows but the newest), a 7-tap shift row
// and the weighted sum of that row.
module ggb_line_cell #(
    parameter int MAX_WIDTH = ggb_pkg::MAX_WIDTH_DEF,
    parameter int ROW       = 0,
    parameter int AW        = $clog2(MAX_WIDTH)
) (
    input  logic                         aclk,
    input  ggb_pkg::cell_ctl_t           ctl,
    input  logic [AW-1:0]                rd_addr,
    input  logic [AW-1:0]                wr_addr,
    input  logic [7:0]                   din,
    output logic [7:0]                   dout,
    output logic [ggb_pkg::PART_W-1:0]   partial
);

    logic [7:0]                 tap_in;
    logic [7:0]                 taps_reg [ggb_pkg::WIN];
    logic [ggb_pkg::PART_W-1:0] part_next;
    logic [ggb_pkg::PART_W-1:0] part_reg;

    generate
        if (ROW < ggb_pkg::LINE_ROWS) begin : g_line
            logic [7:0] mem [MAX_WIDTH];
            logic [7:0] rd_reg;

            always_ff @(posedge aclk) begin
                if (ctl.rd_en) begin
                    rd_reg <= mem[rd_addr];
                end
                if (ctl.wr_en) begin
                    mem[wr_addr] <= din;
                end
            end

            assign tap_in = rd_reg;
        end else begin : g_newest
            assign tap_in = din;
        end
    endgenerate

    // hand the old value up to the row above
    assign dout = tap_in;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            for (int x = 0; x < ggb_pkg::WIN - 1; x++) begin
                taps_reg[x] <= taps_reg[x+1];
            end
            taps_reg[ggb_pkg::WIN-1] <= tap_in;
        end
    end

    always_comb begin
        part_next = '0;
        for (int x = 0; x < ggb_pkg::WIN; x++) begin
            part_next = part_next
                + ggb_pkg::PART_W'(ggb_pkg::KERNEL[ROW][x])
                * ggb_pkg::PART_W'(taps_reg[x]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.sum_en) begin
            part_reg <= part_next;
        end
    end

    assign partial = part_reg;

endmodule

// ===== src/rgb_grey_gaussian_blur_7x7_unit.sv =====
// 7x7 Gaussian blur of the grey image of an RGB pixel stream. Pixels enter in
// raster order, one word per clock; each becomes grey as (307R+604G+113B)>>10.
// The block is a chain of seven row cells: six hold one line buffer each
// (depth MAX_WIDTH) and hand the value they read at the current column up to
// the cell above, the seventh takes the new grey pixel; every cell also keeps
// its 7-tap window row and its weighted row sum. The seven row sums are added,
// then divided by 1068 through a reciprocal multiply. Throughput is one pixel
// per clock while the output is not stalled; a result word passes the line
// buffer read at the edge that takes its pixel, then the window shift, row
// sum, total, multiply and output registers, in that order.
// Only interior pixels (3 or more from every edge) give a result word, with
// its column, row and a flag on the last one of the frame. Output words wait
// in an output register; input is held off only while a finished word at the
// last stage finds that register full and not being drained.
// Registers (APB, 32-bit): 0x0 image_width, 0x4 image_height, 12 bits each,
// reset 640 and 480; values below 7 or above the maximum are clamped. A write
// restarts the frame at column 0, row 0. Write them only while idle. The line
// buffers need no clearing after reset: every read that reaches a result was
// written in the six preceding rows of the same frame.
module rgb_grey_gaussian_blur_7x7_unit #(
    parameter int MAX_WIDTH  = ggb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ggb_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // pixel input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_red,
    input  logic [7:0]                    s_green,
    input  logic [7:0]                    s_blue,
    // blurred output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_blurred,
    output logic [ggb_pkg::COORD_W-1:0]   m_out_col,
    output logic [ggb_pkg::COORD_W-1:0]   m_out_row,
    output logic                          m_frame_last,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ggb_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int CW  = $clog2(MAX_WIDTH);       // column counter
    localparam int RW  = $clog2(MAX_HEIGHT);      // row counter
    localparam int WW  = $clog2(MAX_WIDTH + 1);   // effective width
    localparam int HW  = $clog2(MAX_HEIGHT + 1);  // effective height
    localparam int CXW = (CW > ggb_pkg::COORD_W) ? CW : ggb_pkg::COORD_W;
    localparam int RXW = (RW > ggb_pkg::COORD_W) ? RW : ggb_pkg::COORD_W;
    localparam int W_RST_EFF = (int'(ggb_pkg::WIDTH_RST) > MAX_WIDTH) ?
                               MAX_WIDTH : int'(ggb_pkg::WIDTH_RST);
    localparam int H_RST_EFF = (int'(ggb_pkg::HEIGHT_RST) > MAX_HEIGHT) ?
                               MAX_HEIGHT : int'(ggb_pkg::HEIGHT_RST);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [11:0]   width_cfg_reg;
    logic [11:0]   height_cfg_reg;
    logic [WW-1:0] width_eff_reg;
    logic [HW-1:0] height_eff_reg;
    logic [WW-1:0] width_clamp;
    logic [HW-1:0] height_clamp;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // clamp the written value into the supported range
    always_comb begin
        if (int'(pwdata[11:0]) < ggb_pkg::MIN_SIZE) begin
            width_clamp  = WW'(ggb_pkg::MIN_SIZE);
        end else if (int'(pwdata[11:0]) > MAX_WIDTH) begin
            width_clamp  = WW'(MAX_WIDTH);
        end else begin
            width_clamp  = WW'(pwdata[11:0]);
        end
        if (int'(pwdata[11:0]) < ggb_pkg::MIN_SIZE) begin
            height_clamp = HW'(ggb_pkg::MIN_SIZE);
        end else if (int'(pwdata[11:0]) > MAX_HEIGHT) begin
            height_clamp = HW'(MAX_HEIGHT);
        end else begin
            height_clamp = HW'(pwdata[11:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= ggb_pkg::WIDTH_RST;
            height_cfg_reg <= ggb_pkg::HEIGHT_RST;
            width_eff_reg  <= WW'(W_RST_EFF);
            height_eff_reg <= HW'(H_RST_EFF);
        end else if (cfg_wr) begin
            unique case (paddr[2])
                ggb_pkg::REG_WIDTH: begin
                    width_cfg_reg <= pwdata[11:0];
                    width_eff_reg <= width_clamp;
                end
                ggb_pkg::REG_HEIGHT: begin
                    height_cfg_reg <= pwdata[11:0];
                    height_eff_reg <= height_clamp;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            ggb_pkg::REG_WIDTH:  prdata = {20'b0, width_cfg_reg};
            ggb_pkg::REG_HEIGHT: prdata = {20'b0, height_cfg_reg};
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control: the whole pipe advances unless a finished word at the
    // last stage finds the output register full and not being drained.
    // ------------------------------------------------------------------
    logic accept;
    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic m_valid_reg;

    assign adv     = !v5_reg || !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign accept  = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Position counters
    // ------------------------------------------------------------------
    logic [CW-1:0]  col_count_reg;
    logic [RW-1:0]  row_count_reg;
    logic           col_wrap;
    logic           row_wrap;
    logic [CXW-1:0] col_x;
    logic [RXW-1:0] row_x;

    assign col_wrap = (WW'(col_count_reg) + WW'(1)) == width_eff_reg;
    assign row_wrap = (HW'(row_count_reg) + HW'(1)) == height_eff_reg;
    assign col_x    = CXW'(col_count_reg) - CXW'(ggb_pkg::HALF_WIN);
    assign row_x    = RXW'(row_count_reg) - RXW'(ggb_pkg::HALF_WIN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else if (cfg_wr) begin
            // restart the frame on any size write
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else if (accept) begin
            if (col_wrap) begin
                col_count_reg <= '0;
                row_count_reg <= row_wrap ? '0 : row_count_reg + RW'(1);
            end else begin
                col_count_reg <= col_count_reg + CW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: pixel registered, line buffers read at its column
    // ------------------------------------------------------------------
    logic [7:0]           red_reg, green_reg, blue_reg;
    logic [CW-1:0]        col1_reg;
    logic                 emit1_reg;
    ggb_pkg::meta_t       meta1_reg, meta2_reg, meta3_reg, meta4_reg, meta5_reg;
    logic [ggb_pkg::GREY_W-1:0] grey_sum;
    logic [7:0]           grey;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            red_reg        <= s_red;
            green_reg      <= s_green;
            blue_reg       <= s_blue;
            col1_reg       <= col_count_reg;
            emit1_reg      <= (col_count_reg >= CW'(ggb_pkg::WIN - 1))
                           && (row_count_reg >= RW'(ggb_pkg::WIN - 1));
            meta1_reg.col  <= col_x[ggb_pkg::COORD_W-1:0];
            meta1_reg.row  <= row_x[ggb_pkg::COORD_W-1:0];
            meta1_reg.last <= col_wrap && row_wrap;
        end
    end

    assign grey_sum = ggb_pkg::GREY_W'(ggb_pkg::COEF_RED) * ggb_pkg::GREY_W'(red_reg)
                    + ggb_pkg::GREY_W'(ggb_pkg::COEF_GRN) * ggb_pkg::GREY_W'(green_reg)
                    + ggb_pkg::GREY_W'(ggb_pkg::COEF_BLU) * ggb_pkg::GREY_W'(blue_reg);
    assign grey     = grey_sum[ggb_pkg::GREY_W-1:ggb_pkg::GREY_SHIFT];

    // ------------------------------------------------------------------
    // Row cells: newest row takes the grey pixel, each cell passes the
    // value it read up to the row above, which writes it back.
    // ------------------------------------------------------------------
    ggb_pkg::cell_ctl_t         cell_ctl;
    logic [7:0]                 chain [ggb_pkg::WIN+1];
    logic [ggb_pkg::PART_W-1:0] partial [ggb_pkg::WIN];

    assign cell_ctl.rd_en  = accept;
    assign cell_ctl.wr_en  = adv && v1_reg;
    assign cell_ctl.sum_en = adv;
    assign chain[ggb_pkg::WIN] = grey;

    generate
        for (genvar k = 0; k < ggb_pkg::WIN; k++) begin : g_cell
            ggb_line_cell #(
                .MAX_WIDTH (MAX_WIDTH),
                .ROW       (k),
                .AW        (CW)
            ) u_cell (
                .aclk    (aclk),
                .ctl     (cell_ctl),
                .rd_addr (col_count_reg),
                .wr_addr (col1_reg),
                .din     (chain[k+1]),
                .dout    (chain[k]),
                .partial (partial[k])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Stages 2..5: window shifted, row sums, total, reciprocal multiply.
    // Past stage 1 only pixels that give a result stay valid.
    // ------------------------------------------------------------------
    logic [ggb_pkg::SUM_W-1:0]  total_next;
    logic [ggb_pkg::SUM_W-1:0]  total_reg;
    logic [ggb_pkg::PROD_W-1:0] prod_reg;

    always_comb begin
        total_next = '0;
        for (int k = 0; k < ggb_pkg::WIN; k++) begin
            total_next = total_next + ggb_pkg::SUM_W'(partial[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg && emit1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            meta2_reg <= meta1_reg;
            meta3_reg <= meta2_reg;
            meta4_reg <= meta3_reg;
            meta5_reg <= meta4_reg;
            total_reg <= total_next;
            prod_reg  <= ggb_pkg::PROD_W'(total_reg)
                       * ggb_pkg::PROD_W'(ggb_pkg::DIV_MULT);
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [7:0]     blurred_reg;
    ggb_pkg::meta_t m_meta_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv && v5_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && v5_reg) begin
            blurred_reg <= prod_reg[ggb_pkg::DIV_SHIFT+7:ggb_pkg::DIV_SHIFT];
            m_meta_reg  <= meta5_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_blurred    = blurred_reg;
    assign m_out_col    = m_meta_reg.col;
    assign m_out_row    = m_meta_reg.row;
    assign m_frame_last = m_meta_reg.last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        WW'(col_count_reg) < width_eff_reg)
        else $error("column counter beyond image width");

    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        HW'(row_count_reg) < height_eff_reg)
        else $error("row counter beyond image height");

    a_col_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && col_wrap |=> col_count_reg == '0)
        else $error("column counter did not wrap at end of row");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        v5_reg && !adv |=> v5_reg && $stable(prod_reg))
        else $error("finished word lost while output stalled");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 11;
    // Leave ample margin for result words still in the pipeline.
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_ITEMS = 456;
    localparam int QUIET_FROM   = RANDOM_ITEMS * 4 / 5;
    localparam int END_GUARD    = 100000;
    // About 1.5k pixels with idling and stalls, plus drains, taken many times over.
    localparam int TIMEOUT_NS   = 5_000_000;
    localparam int MAX_PRINTS   = 50;
    localparam int GREY_DIV     = 1068;

    // Blur kernel. It is symmetric in both directions, so index order does not matter.
    localparam logic [6:0][6:0][6:0] BLUR_TAPS = {
        7'd0, 7'd0,  7'd0,   7'd5,   7'd0,   7'd0,  7'd0,
        7'd0, 7'd5,  7'd18,  7'd32,  7'd18,  7'd5,  7'd0,
        7'd0, 7'd18, 7'd64,  7'd100, 7'd64,  7'd18, 7'd0,
        7'd5, 7'd32, 7'd100, 7'd100, 7'd100, 7'd32, 7'd5,
        7'd0, 7'd18, 7'd64,  7'd100, 7'd64,  7'd18, 7'd0,
        7'd0, 7'd5,  7'd18,  7'd32,  7'd18,  7'd5,  7'd0,
        7'd0, 7'd0,  7'd0,   7'd5,   7'd0,   7'd0,  7'd0
    };

    // One blurred word as it should leave the block.
    typedef struct packed {
        logic [7:0]                  blurred;
        logic [ggb_pkg::COORD_W-1:0] col;
        logic [ggb_pkg::COORD_W-1:0] row;
        logic                        last;
    } blur_word_t;

    // One directed frame: sizes to write (-1 keeps the current ones), pixels to
    // stream, and the blurred value of a flat frame (-1 streams random pixels).
    typedef struct packed {
        int         wv;
        int         hv;
        int         count;
        int         want;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } frame_plan_t;

    localparam int PLAN_ROWS = 12;
    localparam frame_plan_t FRAME_PLAN [PLAN_ROWS] = '{
        // reset size 640 x 480, a short run inside the first row gives no word
        '{-1,   -1,   64,  -1,  8'd0,   8'd0,   8'd0},
        // flat 7 x 7 frames: the single result equals the grey level
        '{7,    7,    49,  0,   8'd0,   8'd0,   8'd0},
        '{7,    7,    49,  255, 8'd255, 8'd255, 8'd255},
        '{7,    7,    49,  76,  8'd255, 8'd0,   8'd0},
        '{7,    7,    49,  150, 8'd0,   8'd255, 8'd0},
        '{7,    7,    49,  28,  8'd0,   8'd0,   8'd255},
        // sizes below the minimum clamp up to 7 x 7, then a 9 x 8 frame
        '{0,    6,    49,  128, 8'd128, 8'd128, 8'd128},
        '{9,    8,    72,  -1,  8'd0,   8'd0,   8'd0},
        // two frames back to back: counters wrap, last flag on each frame end
        '{8,    7,    112, -1,  8'd0,   8'd0,   8'd0},
        // widest line: width clamps to the maximum, height clamps up to 7
        '{4095, 0,    120, -1,  8'd0,   8'd0,   8'd0},
        // tallest frame, cut short: the next write restarts mid-frame
        '{7,    4095, 84,  -1,  8'd0,   8'd0,   8'd0},
        '{31,   2048, 248, -1,  8'd0,   8'd0,   8'd0}
    };

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic [7:0]                   s_red = '0;
    logic [7:0]                   s_green = '0;
    logic [7:0]                   s_blue = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b1;
    logic [7:0]                   m_blurred;
    logic [ggb_pkg::COORD_W-1:0]  m_out_col;
    logic [ggb_pkg::COORD_W-1:0]  m_out_row;
    logic                         m_frame_last;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [ggb_pkg::PADDR_W-1:0]  paddr = '0;
    logic [31:0]                  pwdata = '0;
    logic [31:0]                  prdata;
    logic                         pready;

    // Predictor state: size registers, six line buffers, the 7x7 window and
    // the raster position of the next pixel.
    logic [11:0]         size_w = ggb_pkg::WIDTH_RST;
    logic [11:0]         size_h = ggb_pkg::HEIGHT_RST;
    logic [7:0]          line_mem [ggb_pkg::LINE_ROWS][ggb_pkg::MAX_WIDTH_DEF];
    logic [7:0]          win [ggb_pkg::WIN][ggb_pkg::WIN];
    int unsigned         col_pos = 0;
    int unsigned         row_pos = 0;
    int                  pinned_blur = -1;

    blur_word_t          pending_blur [$];
    blur_word_t          exp_word;

    int                  mismatches = 0;
    int                  pixels_fed = 0;
    int                  words_checked = 0;
    int                  settings_used = 0;
    int                  gap_odds = 0;
    int                  stall_odds = 0;
    int                  stall_left = 0;

    rgb_grey_gaussian_blur_7x7_unit i_dut (
        .aclk,
        .aresetn,
        .s_valid,
        .s_ready,
        .s_red,
        .s_green,
        .s_blue,
        .m_valid,
        .m_ready,
        .m_blurred,
        .m_out_col,
        .m_out_row,
        .m_frame_last,
        .psel,
        .penable,
        .pwrite,
        .paddr,
        .pwdata,
        .prdata,
        .pready
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // Print one line per mismatch (up to a cap) and count every one.
    task automatic note_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        end
    endtask

    function automatic int unsigned clamp_dim(input logic [11:0] v, input int unsigned hi);
        if (v < ggb_pkg::MIN_SIZE) return ggb_pkg::MIN_SIZE;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advance the predictor by one accepted pixel; queue a word for interior pixels.
    function automatic void predict_blur(input logic [7:0] red, input logic [7:0] green,
                                         input logic [7:0] blue);
        int unsigned w, h, c, r, acc;
        int          k, x, y;
        logic [7:0]  grey;
        logic [7:0]  column [ggb_pkg::WIN];
        blur_word_t  word;
        w = clamp_dim(size_w, ggb_pkg::MAX_WIDTH_DEF);
        h = clamp_dim(size_h, ggb_pkg::MAX_HEIGHT_DEF);
        c = (col_pos >= w) ? 0 : col_pos;
        r = (row_pos >= h) ? 0 : row_pos;
        acc = 307 * red + 604 * green + 113 * blue;
        grey = 8'(acc >> 10);

        // pull the column out of the line buffers, oldest row first, then push the new pixel
        for (k = 0; k < ggb_pkg::LINE_ROWS; k++) column[k] = line_mem[k][c];
        column[ggb_pkg::LINE_ROWS] = grey;
        for (k = 0; k < ggb_pkg::LINE_ROWS - 1; k++) line_mem[k][c] = line_mem[k + 1][c];
        line_mem[ggb_pkg::LINE_ROWS - 1][c] = grey;

        for (y = 0; y < ggb_pkg::WIN; y++) begin
            for (x = 0; x < ggb_pkg::WIN - 1; x++) win[y][x] = win[y][x + 1];
            win[y][ggb_pkg::WIN - 1] = column[y];
        end

        if (c >= ggb_pkg::WIN - 1 && r >= ggb_pkg::WIN - 1) begin
            acc = 0;
            for (y = 0; y < ggb_pkg::WIN; y++) begin
                for (x = 0; x < ggb_pkg::WIN; x++) acc += BLUR_TAPS[y][x] * win[y][x];
            end
            word.blurred = (pinned_blur >= 0) ? 8'(pinned_blur) : 8'(acc / GREY_DIV);
            word.col = ggb_pkg::COORD_W'(c - ggb_pkg::HALF_WIN);
            word.row = ggb_pkg::COORD_W'(r - ggb_pkg::HALF_WIN);
            word.last = (c + 1 == w) && (r + 1 == h);
            pending_blur.push_back(word);
        end

        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endfunction

    // Predict on every accepted pixel and check every accepted result word.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            predict_blur(s_red, s_green, s_blue);
            pixels_fed++;
        end
        if (aresetn && m_valid && m_ready) begin
            if (pending_blur.size() == 0) begin
                note_mismatch("result word with nothing pending, blurred",
                              int'(m_blurred), -1);
            end else begin
                exp_word = pending_blur.pop_front();
                words_checked++;
                if (m_blurred !== exp_word.blurred)
                    note_mismatch("blurred", int'(m_blurred), int'(exp_word.blurred));
                if (m_out_col !== exp_word.col)
                    note_mismatch("out_col", int'(m_out_col), int'(exp_word.col));
                if (m_out_row !== exp_word.row)
                    note_mismatch("out_row", int'(m_out_row), int'(exp_word.row));
                if (m_frame_last !== exp_word.last)
                    note_mismatch("frame_last", int'(m_frame_last), int'(exp_word.last));
            end
        end
    end

    // Receiver: drop ready in bursts of random length while stalls are enabled.
    always @(posedge aclk) begin
        if (!aresetn || stall_odds == 0) begin
            m_ready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < stall_odds) begin
            m_ready <= 1'b0;
            stall_left <= $urandom_range(0, 8);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // APB read; prdata is taken at the access edge.
    task automatic check_reg(input logic idx, input int want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== 32'(want)) note_mismatch("register read-back", int'(prdata), want);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // APB write; mirror it into the predictor at the write edge, which also
    // restarts the frame. Read back values that need no clamping.
    task automatic write_size(input logic idx, input int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == ggb_pkg::REG_WIDTH) size_w = value[11:0];
        else size_h = value[11:0];
        col_pos = 0;
        row_pos = 0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        if (value >= ggb_pkg::MIN_SIZE && value <= ggb_pkg::MAX_WIDTH_DEF)
            check_reg(idx, value);
    endtask

    // Hold the input, wait for every pending word, then let the pipeline empty.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_blur.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_channel();
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int pick_odds();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 15;
            default: return 40;
        endcase
    endfunction

    // Stream pixels, flat or random. At index pause_at, hold off until every
    // expected word has come back.
    task automatic feed_pixels(input int count, input logic [7:0] red, input logic [7:0] green,
                               input logic [7:0] blue, input bit scramble, input int pause_at);
        int k;
        for (k = 0; k < count; k++) begin
            if (k == pause_at) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (pending_blur.size() != 0);
            end else if (gap_odds != 0 && $urandom_range(0, 99) < gap_odds) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
            s_valid <= 1'b1;
            if (scramble) begin
                s_red <= pick_channel();
                s_green <= pick_channel();
                s_blue <= pick_channel();
            end else begin
                s_red <= red;
                s_green <= green;
                s_blue <= blue;
            end
            do @(posedge aclk); while (!s_ready);
        end
    endtask

    initial begin
        frame_plan_t plan;
        int          p, pixels, wv, hv, area, pause_at, random_items, guard;
        bit          paused_once;
        random_items = 0;
        paused_once = 1'b0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Registers come out of reset at 640 x 480.
        check_reg(ggb_pkg::REG_WIDTH, 640);
        check_reg(ggb_pkg::REG_HEIGHT, 480);

        // Directed frames, with moderate idling on both sides.
        gap_odds = 20;
        stall_odds = 20;
        for (p = 0; p < PLAN_ROWS; p++) begin
            plan = FRAME_PLAN[p];
            drain_results();
            if (plan.wv >= 0) begin
                write_size(ggb_pkg::REG_WIDTH, plan.wv);
                write_size(ggb_pkg::REG_HEIGHT, plan.hv);
                settings_used++;
            end
            pinned_blur = plan.want;
            feed_pixels(plan.count, plan.red, plan.green, plan.blue, plan.want < 0, -1);
        end
        drain_results();
        pinned_blur = -1;

        // Random frames: mostly small whole frames, some cut short, a few with
        // clamped or huge sizes. The last fifth runs without any idling.
        while (random_items < RANDOM_ITEMS) begin
            drain_results();
            case ($urandom_range(0, 9))
                0: begin
                    wv = $urandom_range(0, 6);
                    hv = $urandom_range(0, 6);
                end
                1: begin
                    wv = $urandom_range(0, 1) ? ggb_pkg::MAX_WIDTH_DEF
                                              : $urandom_range(2049, 4095);
                    hv = $urandom_range(0, 4095);
                end
                default: begin
                    wv = $urandom_range(7, 20);
                    hv = $urandom_range(7, 14);
                end
            endcase
            write_size(ggb_pkg::REG_WIDTH, wv);
            write_size(ggb_pkg::REG_HEIGHT, hv);
            settings_used++;

            area = clamp_dim(size_w, ggb_pkg::MAX_WIDTH_DEF)
                 * clamp_dim(size_h, ggb_pkg::MAX_HEIGHT_DEF);
            if (area > 4096) pixels = $urandom_range(1, 300);
            else if ($urandom_range(0, 2) == 0) pixels = $urandom_range(1, 2 * area);
            else pixels = area * $urandom_range(1, 2);

            // stop each frame at the quiet boundary and at the item budget
            if (random_items < QUIET_FROM) begin
                if (pixels > QUIET_FROM - random_items) pixels = QUIET_FROM - random_items;
            end else if (pixels > RANDOM_ITEMS - random_items) begin
                pixels = RANDOM_ITEMS - random_items;
            end

            if (random_items >= QUIET_FROM) begin
                gap_odds = 0;
                stall_odds = 0;
            end else begin
                gap_odds = pick_odds();
                stall_odds = pick_odds();
            end

            // hold off mid-stream at least once until the block has caught up
            if (!paused_once) pause_at = pixels / 2;
            else if ($urandom_range(0, 4) == 0) pause_at = $urandom_range(0, pixels - 1);
            else pause_at = -1;
            paused_once = 1'b1;

            feed_pixels(pixels, 8'h00, 8'h00, 8'h00, 1'b1, pause_at);
            random_items += pixels;
        end

        // Wait out the last words, with a limit, then give the pipeline time.
        s_valid <= 1'b0;
        for (guard = 0; guard < END_GUARD && pending_blur.size() != 0; guard++) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_blur.size() != 0) begin
            note_mismatch("blurred words never delivered", 0, pending_blur.size());
        end

        $display("covered %0d pixels over %0d frame sizes, including clamped and maximum sizes",
                 pixels_fed, settings_used);
        $display("checked %0d blurred words field by field, %0d mismatches",
                 words_checked, mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("timeout: run did not complete");
        $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/ggb_pkg.sv
src/ggb_line_cell.sv
src/rgb_grey_gaussian_blur_7x7_unit.sv
bench/tb_top.sv
